// ===== sv/mic_rms_level_meter_with_timeout_unit_macros.svh =====
// Assertion helpers for the level meter checker.
// Both expect clk and arst_n in scope.
`ifndef MIC_RMS_LEVEL_METER_WITH_TIMEOUT_UNIT_MACROS_SVH
`define MIC_RMS_LEVEL_METER_WITH_TIMEOUT_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("level meter check failed");

// Consequent must hold in the cycle after the antecedent.
`define MRL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("level meter check failed");

`endif

// ===== sv/mrl_pkg.sv =====
`default_nettype none

package mrl_pkg;

	// Frame and datapath sizing
	localparam int MAX_FRAME = 1024;
	localparam int FRAME_W   = $clog2(MAX_FRAME + 1);
	localparam int SAMPLE_W  = 16;
	localparam int SQ_W      = 31;                          // 32768^2 fits in 31 bits
	localparam int SUM_W     = SQ_W + $clog2(MAX_FRAME);
	localparam int Q_W       = 31;                          // mean square never above 2^30
	localparam int ROOT_W    = 16;
	localparam int SH_W      = (SUM_W > 2 * ROOT_W) ? SUM_W : 2 * ROOT_W;
	localparam int STEP_W    = $clog2(SH_W + 1);
	localparam int REM_W     = 20;
	localparam int LDIV_W    = 11;
	localparam int DVS_W     = (FRAME_W > LDIV_W) ? FRAME_W : LDIV_W;
	localparam int GATE_W    = 8;
	localparam int LIMIT_W   = 20;
	localparam int TOTAL_W   = 21;
	localparam int LEVEL_W   = 7;
	localparam int SMOOTH_W  = 9;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// Divide by three as multiply and shift, exact for sums up to 300
	localparam logic [7:0] SMOOTH_MUL   = 8'd171;
	localparam int         SMOOTH_SHIFT = 9;

	// Stream widths
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 2;

	// Register port
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [LDIV_W-1:0]  DIVISOR_RST = 11'd80;
	localparam logic [GATE_W-1:0]  GATE_RST    = 8'd8;
	localparam logic [LIMIT_W-1:0] LIMIT_RST   = 20'd192000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DIVISOR = 2'd0,
		REG_GATE    = 2'd1,
		REG_LIMIT   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_START  = 2'd1,
		CMD_STOP   = 2'd2
	} cmd_t;

	typedef enum logic {
		ITER_DIV  = 1'b0,
		ITER_SQRT = 1'b1
	} iter_mode_t;

	typedef struct packed {
		logic [LDIV_W-1:0]  level_divisor;
		logic [GATE_W-1:0]  noise_gate;
		logic [LIMIT_W-1:0] listen_limit;
	} cfg_t;

	typedef struct packed {
		logic              start;
		iter_mode_t        mode;
		logic [SH_W-1:0]   operand;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} iter_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [SH_W-1:0]   quot;
		logic [ROOT_W-1:0] root;
	} iter_rsp_t;

endpackage

`default_nettype wire

// ===== sv/mic_rms_level_meter_with_timeout_unit.sv =====
// Microphone RMS level meter with listening window and timeout. Items come
// in on the s_ stream (sample in s_tdata, command in s_tuser, frame end on
// s_tlast), one result per item goes out on the m_ stream. The block takes
// one item at a time. On a frame end the single compare-subtract unit runs
// the mean-square division (one quotient bit per cycle), the square root
// (one digit per cycle) and the level division in turn. A stalled result
// stream holds back the next item until the output register is free. A
// finished result waits in the output register while the next item is taken.
// Registers: level_divisor at 0x0, noise_gate at 0x4, listen_limit at 0x8.
`default_nettype none

module mic_rms_level_meter_with_timeout_unit import mrl_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
	input  wire logic [S_TUSER_W-1:0] s_tuser,   // [1:0] command
	input  wire logic                 s_tlast,
	// result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,   // [15:0] forward_sample, [22:16] level,
	                                             // [23] listening, [24] timed_out
	output logic      [M_TUSER_W-1:0] m_tuser,   // [0] forward_valid, [1] level_valid
	// register port
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [DATA_W-1:0]    pwdata,
	output logic      [DATA_W-1:0]    prdata,
	output logic                      pready
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_SQR    = 10'b0000000010,
		ST_ACC    = 10'b0000000100,
		ST_START  = 10'b0000001000,
		ST_DIV    = 10'b0000010000,
		ST_SQRT   = 10'b0000100000,
		ST_LDIV   = 10'b0001000000,
		ST_GATE   = 10'b0010000000,
		ST_SMOOTH = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	state_t                     state_q;
	cfg_t                       cfg;
	iter_req_t                  req;
	iter_rsp_t                  rsp;

	logic [S_TUSER_W-1:0]       cmd_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic [SQ_W-1:0]            sq_q;
	logic [SUM_W-1:0]           sum_q;
	logic [FRAME_W-1:0]         count_q;
	logic [LEVEL_W-1:0]         level_q;
	logic                       listen_q;
	logic [TOTAL_W-1:0]         total_q;
	logic [LEVEL_W-1:0]         gated_q;
	logic                       fwd_q;
	logic                       lvl_valid_q;
	logic                       tout_q;
	logic                       m_tvalid_q;
	logic [M_TDATA_W-1:0]       m_tdata_q;
	logic [M_TUSER_W-1:0]       m_tuser_q;

	logic                       accept;
	logic                       out_load;
	logic [SAMPLE_W-1:0]        mag;
	logic [2*SAMPLE_W-1:0]      sq_full;
	logic [ROOT_W-1:0]          lv;
	logic [ROOT_W-1:0]          lv_gated;
	logic [TOTAL_W:0]           total_sum;
	logic [SMOOTH_W-1:0]        smooth_in;
	logic [SMOOTH_W+7:0]        smooth_prod;
	logic [DVS_W-1:0]           cnt_dvs;
	logic [DVS_W-1:0]           lvl_dvs;
	logic [SAMPLE_W-1:0]        fwd_sample;

	mrl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	mrl_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// Square of the sample magnitude
	assign mag     = sample_q[SAMPLE_W-1] ? SAMPLE_W'(-sample_q) : SAMPLE_W'(sample_q);
	assign sq_full = {{SAMPLE_W{1'b0}}, mag} * {{SAMPLE_W{1'b0}}, mag};

	// Zero divisors act as one
	assign cnt_dvs = (count_q == '0) ? DVS_W'(1) : DVS_W'(count_q);
	assign lvl_dvs = (cfg.level_divisor == '0) ? DVS_W'(1) : DVS_W'(cfg.level_divisor);

	// Requests to the shared unit
	always_comb begin
		req.start   = 1'b0;
		req.mode    = ITER_DIV;
		req.operand = SH_W'(sum_q);
		req.divisor = cnt_dvs;
		req.steps   = STEP_W'(SH_W);
		unique case (state_q)
			ST_START: req.start = 1'b1;
			ST_DIV: begin
				req.start   = rsp.done;
				req.mode    = ITER_SQRT;
				req.operand = {1'b0, rsp.quot[Q_W-1:0], {(SH_W-2*ROOT_W){1'b0}}};
				req.steps   = STEP_W'(ROOT_W);
			end
			ST_SQRT: begin
				req.start   = rsp.done;
				req.operand = {rsp.root, {(SH_W-ROOT_W){1'b0}}};
				req.divisor = lvl_dvs;
				req.steps   = STEP_W'(ROOT_W);
			end
			default: ;
		endcase
	end

	// Gate and cap of the raw level
	assign lv       = rsp.quot[ROOT_W-1:0];
	assign lv_gated = (lv < ROOT_W'(cfg.noise_gate)) ? '0 : lv - ROOT_W'(cfg.noise_gate);
	assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(count_q);

	// Smoothing (2*old + new) / 3
	assign smooth_in   = {1'b0, level_q, 1'b0} + SMOOTH_W'(gated_q);
	assign smooth_prod = (SMOOTH_W+8)'(smooth_in) * (SMOOTH_W+8)'(SMOOTH_MUL);

	// Sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			level_q     <= '0;
			listen_q    <= 1'b0;
			total_q     <= '0;
			fwd_q       <= 1'b0;
			lvl_valid_q <= 1'b0;
			tout_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fwd_q       <= 1'b0;
						lvl_valid_q <= 1'b0;
						tout_q      <= 1'b0;
						state_q     <= ST_SQR;
					end
				end
				ST_SQR: state_q <= ST_ACC;
				ST_ACC: begin
					state_q <= ST_OUT;
					unique case (cmd_q)
						CMD_START: begin
							listen_q <= 1'b1;
							total_q  <= '0;
						end
						CMD_STOP: begin
							listen_q <= 1'b0;
							total_q  <= '0;
							level_q  <= '0;
						end
						CMD_SAMPLE: begin
							if (count_q < FRAME_W'(MAX_FRAME)) begin
								sum_q   <= sum_q + SUM_W'(sq_q);
								count_q <= count_q + FRAME_W'(1);
							end
							fwd_q <= listen_q;
							if (last_q) begin
								state_q <= ST_START;
							end
						end
						default: ;
					endcase
				end
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (rsp.done) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (rsp.done) begin
						state_q <= ST_LDIV;
					end
				end
				ST_LDIV: begin
					if (rsp.done) begin
						state_q <= ST_GATE;
					end
				end
				ST_GATE: begin
					if (listen_q) begin
						total_q <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
					end
					sum_q   <= '0;
					count_q <= '0;
					state_q <= ST_SMOOTH;
				end
				ST_SMOOTH: begin
					lvl_valid_q <= 1'b1;
					if (listen_q && (total_q >= TOTAL_W'(cfg.listen_limit))) begin
						listen_q <= 1'b0;
						level_q  <= '0;
						tout_q   <= 1'b1;
					end else begin
						level_q <= smooth_prod[SMOOTH_SHIFT +: LEVEL_W];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item capture and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_tuser;
			sample_q <= s_tdata;
			last_q   <= s_tlast;
		end
		if (state_q == ST_SQR) begin
			sq_q <= sq_full[SQ_W-1:0];
		end
		if (state_q == ST_GATE) begin
			gated_q <= (lv_gated > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : lv_gated[LEVEL_W-1:0];
		end
	end

	// Output register
	assign fwd_sample = fwd_q ? SAMPLE_W'(sample_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= M_TDATA_W'({tout_q, listen_q, level_q, fwd_sample});
			m_tuser_q <= {lvl_valid_q, fwd_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== sv/mrl_cfg.sv =====
`default_nettype none

// Register file behind the APB-style port
module mrl_cfg import mrl_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output cfg_t                   cfg
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	cfg_t                 cfg_q;

	assign wr_en = psel & penable & pwrite;
	assign idx   = paddr[ADDR_W-1:2];
	assign cfg   = cfg_q;

	// Register writes; addresses past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_divisor <= DIVISOR_RST;
			cfg_q.noise_gate    <= GATE_RST;
			cfg_q.listen_limit  <= LIMIT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DIVISOR: cfg_q.level_divisor <= pwdata[LDIV_W-1:0];
				REG_GATE:    cfg_q.noise_gate    <= pwdata[GATE_W-1:0];
				REG_LIMIT:   cfg_q.listen_limit  <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_DIVISOR: prdata = DATA_W'(cfg_q.level_divisor);
			REG_GATE:    prdata = DATA_W'(cfg_q.noise_gate);
			REG_LIMIT:   prdata = DATA_W'(cfg_q.listen_limit);
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/mrl_iter.sv =====
`default_nettype none

// Shared compare-subtract unit: one restoring division step or one
// square root digit per cycle, for as many steps as the request asks.
module mrl_iter import mrl_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire iter_req_t req,
	output iter_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	iter_mode_t        mode_q;
	logic [REM_W-1:0]  rem_q;
	logic [SH_W-1:0]   sh_q;
	logic [ROOT_W-1:0] root_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [REM_W-1:0]  op_a;
	logic [REM_W-1:0]  op_b;
	logic [REM_W:0]    diff;
	logic              ge;

	// Operand select: bring down one bit (divide) or two bits (root)
	always_comb begin
		unique case (mode_q)
			ITER_SQRT: begin
				op_a = {rem_q[REM_W-3:0], sh_q[SH_W-1 -: 2]};
				op_b = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
			end
			ITER_DIV: begin
				op_a = {rem_q[REM_W-2:0], sh_q[SH_W-1]};
				op_b = {{(REM_W-DVS_W){1'b0}}, dvs_q};
			end
		endcase
	end

	assign diff = {1'b0, op_a} - {1'b0, op_b};
	assign ge   = ~diff[REM_W];

	// Step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= ITER_DIV;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
			mode_q <= req.mode;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			sh_q   <= req.operand;
			root_q <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[REM_W-1:0] : op_a;
			if (mode_q == ITER_SQRT) begin
				sh_q   <= {sh_q[SH_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], ge};
			end else begin
				sh_q <= {sh_q[SH_W-2:0], ge};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = sh_q;
	assign rsp.root = root_q;

endmodule

`default_nettype wire

// ===== sv/mrl_checker.sv =====
`default_nettype none
`include "mic_rms_level_meter_with_timeout_unit_macros.svh"

// Port-level checks on the result stream
module mrl_checker import mrl_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser
);

	// Smoothed level never leaves 0..100
	`MRL_ASSERT_SAME(a_level_range, m_tvalid, m_tdata[22:16] <= 7'd100)

	// A sample that is not forwarded shows as zero
	`MRL_ASSERT_SAME(a_fwd_zero, m_tvalid && !m_tuser[0], m_tdata[15:0] == 16'd0)

	// A timeout happens only on a frame end and closes the window with level zero
	`MRL_ASSERT_SAME(a_timeout, m_tvalid && m_tdata[24], m_tuser[1] && !m_tdata[23] && m_tdata[22:16] == 7'd0)

	// A stalled result stays offered
	`MRL_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)

endmodule

bind mic_rms_level_meter_with_timeout_unit mrl_checker u_mrl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
